[rtl/core/plldiv_pkg.sv]
`timescale 1ns / 1ps

package plldiv_pkg;

  localparam int XTAL_W   = 26;
  localparam int TARGET_W = 27;
  localparam int HZ_W     = 27;
  localparam int SEL_W    = 5;
  localparam int MB_W     = 4;
  localparam int WS_W     = 2;

  // Divider: divisor is at most 16, so the partial remainder stays narrow
  localparam int DIG_W     = 4;
  localparam int DIV_STEPS = 7;
  localparam int DIV_W     = DIG_W * DIV_STEPS;
  localparam int REM_W     = 5;

  localparam int PROD_W  = 32;
  localparam int MULA_W  = 27;

  localparam logic [HZ_W-1:0]     STAGE_MIN_HZ   = HZ_W'(18000000);
  localparam logic [HZ_W-1:0]     STAGE_A_MAX_HZ = HZ_W'(72000000);
  localparam logic [TARGET_W-1:0] WS_ONE_HZ      = TARGET_W'(24000000);
  localparam logic [TARGET_W-1:0] WS_TWO_HZ      = TARGET_W'(48000000);

  localparam logic [SEL_W-1:0] DIV_FIRST = SEL_W'(1);
  localparam logic [SEL_W-1:0] DIV_LAST  = SEL_W'(16);

  localparam int              MA_COUNT = 9;
  localparam int              MAI_W    = 4;
  localparam logic [MAI_W-1:0] MAI_LAST = MAI_W'(MA_COUNT - 1);

  localparam logic [MB_W-1:0]  MB_FIRST     = MB_W'(4);
  localparam logic [MB_W-1:0]  MB_HALF_CODE = MB_W'(10);
  localparam logic [SEL_W-1:0] MB_HALF_NUM  = SEL_W'(13);

  localparam logic [WS_W-1:0] WS_ZERO = WS_W'(0);
  localparam logic [WS_W-1:0] WS_ONE  = WS_W'(1);
  localparam logic [WS_W-1:0] WS_TWO  = WS_W'(2);

  // First-stage multiplier by position in search order
  function automatic logic [SEL_W-1:0] ma_of(input logic [MAI_W-1:0] idx);
    logic [SEL_W-1:0] val;
    case (idx)
      4'd7:    val = SEL_W'(16);
      4'd8:    val = SEL_W'(20);
      default: val = SEL_W'(8) + SEL_W'(idx);
    endcase
    return val;
  endfunction

  // Second-stage multiplier numerator; the half code stands for 13 / 2
  function automatic logic [SEL_W-1:0] mb_num(input logic [MB_W-1:0] code);
    logic [SEL_W-1:0] val;
    if (code == MB_HALF_CODE) begin
      val = MB_HALF_NUM;
    end else begin
      val = SEL_W'(code);
    end
    return val;
  endfunction

endpackage

[rtl/core/plldiv_divider.sv]
`timescale 1ns / 1ps

module plldiv_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [plldiv_pkg::DIV_W-1:0]   dividend,
  input  logic [plldiv_pkg::SEL_W-1:0]   divisor,
  output logic                           done,
  output logic [plldiv_pkg::DIV_W-1:0]   quotient
);
  import plldiv_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic [DIG_W-1:0] digit;

  // One quotient digit per cycle: a few narrow restoring steps
  always_comb begin
    rem_nxt = rem_r;
    digit   = '0;
    for (int i = 0; i < DIG_W; i++) begin
      rem_nxt = {rem_nxt[REM_W-2:0], quo_r[DIV_W-1-i]};
      if (rem_nxt >= divisor) begin
        rem_nxt           = rem_nxt - divisor;
        digit[DIG_W-1-i]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        quo_r <= {quo_r[DIV_W-DIG_W-1:0], digit};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/core/pll_divider_search.sv]
`timescale 1ns / 1ps
// Search: for each first-stage predivider the shared divider runs once, then each first-stage
// multiplier goes through the shared multiplier; each of the Q (0..144) first-stage settings
// inside 18..72 MHz runs every second-stage setting. Each division holds its state on the
// shared 4-bit-per-cycle divider, each second-stage multiplier on the shared multiplier.
// Throughput: one request per search; a finished result waits in its own register meanwhile.
// Reset: synchronous, active low; clears the sequencer and the result valid.
module pll_divider_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [plldiv_pkg::XTAL_W-1:0]     in_crystal_hz,
  input  logic [plldiv_pkg::TARGET_W-1:0]   in_target_hz,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [plldiv_pkg::HZ_W-1:0]       out_best_hz,
  output logic [plldiv_pkg::SEL_W-1:0]      out_prediv_two,
  output logic [plldiv_pkg::SEL_W-1:0]      out_mult_two,
  output logic [plldiv_pkg::SEL_W-1:0]      out_prediv_one,
  output logic [plldiv_pkg::MB_W-1:0]       out_mult_one,
  output logic [plldiv_pkg::WS_W-1:0]       out_flash_ws
);
  import plldiv_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_MUL_A,
    ST_CHK_A,
    ST_NEXT_A,
    ST_DIV_B,
    ST_EVAL,
    ST_FINISH
  } state_t;

  state_t state_r;

  logic [XTAL_W-1:0]   xtal_r;
  logic [TARGET_W-1:0] target_r;
  logic [SEL_W-1:0]    da_r;
  logic [MAI_W-1:0]    mai_r;
  logic [SEL_W-1:0]    db_r;
  logic [MB_W-1:0]     mb_r;
  logic [XTAL_W-1:0]   qa_r;
  logic [HZ_W-1:0]     fa_r;
  logic [HZ_W-1:0]     qb_r;
  logic                go_r;

  logic [PROD_W-1:0]   prod_r;
  logic                ev_vld_r;
  logic                ev_half_r;
  logic [SEL_W-1:0]    ev_da_r;
  logic [SEL_W-1:0]    ev_ma_r;
  logic [SEL_W-1:0]    ev_db_r;
  logic [MB_W-1:0]     ev_mb_r;

  logic [HZ_W-1:0]     top_r;
  logic [SEL_W-1:0]    best_da_r;
  logic [SEL_W-1:0]    best_ma_r;
  logic [SEL_W-1:0]    best_db_r;
  logic [MB_W-1:0]     best_mb_r;

  logic                out_valid_r;
  logic                found_r;
  logic [HZ_W-1:0]     best_hz_r;
  logic [SEL_W-1:0]    prediv_two_r;
  logic [SEL_W-1:0]    mult_two_r;
  logic [SEL_W-1:0]    prediv_one_r;
  logic [MB_W-1:0]     mult_one_r;
  logic [WS_W-1:0]     flash_ws_r;

  logic [DIV_W-1:0]    div_dividend;
  logic [SEL_W-1:0]    div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_quotient;
  logic [MULA_W-1:0]   mul_a;
  logic [SEL_W-1:0]    mul_b;
  logic [PROD_W-1:0]   fb;
  logic                fb_better;
  logic                fa_ok;
  logic [WS_W-1:0]     ws_calc;

  always_comb begin
    if (state_r == ST_DIV_B) begin
      div_dividend = DIV_W'(fa_r);
      div_divisor  = db_r;
    end else begin
      div_dividend = DIV_W'(xtal_r);
      div_divisor  = da_r;
    end
  end

  plldiv_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Shared multiplier operands
  always_comb begin
    if (state_r == ST_EVAL) begin
      mul_a = qb_r;
      mul_b = mb_num(mb_r);
    end else begin
      mul_a = MULA_W'(qa_r);
      mul_b = ma_of(mai_r);
    end
  end

  assign fb = ev_half_r ? {1'b0, prod_r[PROD_W-1:1]} : prod_r;
  assign fb_better = ev_vld_r
                     && (fb >= PROD_W'(STAGE_MIN_HZ))
                     && (fb <= PROD_W'(target_r))
                     && (fb > PROD_W'(top_r));
  assign fa_ok = (prod_r >= PROD_W'(STAGE_MIN_HZ)) && (prod_r <= PROD_W'(STAGE_A_MAX_HZ));

  always_comb begin
    if (target_r < WS_ONE_HZ) begin
      ws_calc = WS_ZERO;
    end else if (target_r < WS_TWO_HZ) begin
      ws_calc = WS_ONE;
    end else begin
      ws_calc = WS_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r      <= 1'b0;
      ev_vld_r  <= 1'b0;
      prod_r    <= {{(PROD_W-MULA_W){1'b0}}, mul_a} * {{(PROD_W-SEL_W){1'b0}}, mul_b};

      // Drop the result once taken, unless a new one replaces it
      if (out_valid_r && !out_stall && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end

      // Keep the first setting that reaches a new best frequency
      if (fb_better) begin
        top_r     <= fb[HZ_W-1:0];
        best_da_r <= ev_da_r;
        best_ma_r <= ev_ma_r;
        best_db_r <= ev_db_r;
        best_mb_r <= ev_mb_r;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            xtal_r    <= in_crystal_hz;
            target_r  <= in_target_hz;
            top_r     <= '0;
            best_da_r <= '0;
            best_ma_r <= '0;
            best_db_r <= '0;
            best_mb_r <= '0;
            da_r      <= DIV_FIRST;
            go_r      <= 1'b1;
            state_r   <= ST_DIV_A;
          end
        end
        ST_DIV_A: begin
          if (div_done) begin
            qa_r    <= div_quotient[XTAL_W-1:0];
            mai_r   <= '0;
            state_r <= ST_MUL_A;
          end
        end
        ST_MUL_A: begin
          state_r <= ST_CHK_A;
        end
        ST_CHK_A: begin
          if (fa_ok) begin
            fa_r    <= prod_r[HZ_W-1:0];
            db_r    <= DIV_FIRST;
            go_r    <= 1'b1;
            state_r <= ST_DIV_B;
          end else begin
            state_r <= ST_NEXT_A;
          end
        end
        ST_NEXT_A: begin
          if (mai_r == MAI_LAST) begin
            if (da_r == DIV_LAST) begin
              state_r <= ST_FINISH;
            end else begin
              da_r    <= da_r + SEL_W'(1);
              go_r    <= 1'b1;
              state_r <= ST_DIV_A;
            end
          end else begin
            mai_r   <= mai_r + MAI_W'(1);
            state_r <= ST_MUL_A;
          end
        end
        ST_DIV_B: begin
          if (div_done) begin
            qb_r    <= div_quotient[HZ_W-1:0];
            mb_r    <= MB_FIRST;
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          // Issue one product a cycle; the compare follows in the cycle after
          ev_vld_r  <= 1'b1;
          ev_half_r <= (mb_r == MB_HALF_CODE);
          ev_da_r   <= da_r;
          ev_ma_r   <= ma_of(mai_r);
          ev_db_r   <= db_r;
          ev_mb_r   <= mb_r;
          if (mb_r == MB_HALF_CODE) begin
            if (db_r == DIV_LAST) begin
              state_r <= ST_NEXT_A;
            end else begin
              db_r    <= db_r + SEL_W'(1);
              go_r    <= 1'b1;
              state_r <= ST_DIV_B;
            end
          end else begin
            mb_r <= mb_r + MB_W'(1);
          end
        end
        ST_FINISH: begin
          // Hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            found_r       <= (top_r != '0);
            best_hz_r     <= top_r;
            prediv_two_r  <= best_da_r;
            mult_two_r    <= best_ma_r;
            prediv_one_r  <= best_db_r;
            mult_one_r    <= best_mb_r;
            flash_ws_r    <= ws_calc;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_best_hz     = best_hz_r;
  assign out_prediv_two  = prediv_two_r;
  assign out_mult_two    = mult_two_r;
  assign out_prediv_one  = prediv_one_r;
  assign out_mult_one    = mult_one_r;
  assign out_flash_ws    = flash_ws_r;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import plldiv_pkg::*;

  // Bound on a run in which every request needs the longest search, plus the long hold-off
  localparam int CYCLE_LIMIT  = 16_000_000;
  localparam int HOLD_CYCLES  = 90_000;
  localparam int DRAIN_CYCLES = 41_000;
  localparam int N_RANDOM     = 80;
  localparam int CALM_TAIL    = 20;

  typedef struct packed {
    logic [XTAL_W-1:0]   crystal;
    logic [TARGET_W-1:0] target;
  } clock_request_t;

  typedef struct packed {
    logic              found;
    logic [HZ_W-1:0]   best_hz;
    logic [SEL_W-1:0]  prediv_two;
    logic [SEL_W-1:0]  mult_two;
    logic [SEL_W-1:0]  prediv_one;
    logic [MB_W-1:0]   mult_one;
    logic [WS_W-1:0]   flash_ws;
  } pll_setting_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [XTAL_W-1:0]   in_crystal_hz = '0;
  logic [TARGET_W-1:0] in_target_hz = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_found;
  logic [HZ_W-1:0]     out_best_hz;
  logic [SEL_W-1:0]    out_prediv_two;
  logic [SEL_W-1:0]    out_mult_two;
  logic [SEL_W-1:0]    out_prediv_one;
  logic [MB_W-1:0]     out_mult_one;
  logic [WS_W-1:0]     out_flash_ws;

  clock_request_t request_queue[$];
  pll_setting_t   expected_settings[$];
  logic           calm = 1'b0;
  logic           long_hold = 1'b0;
  int             sender_gap = 0;
  int             stall_left = 0;
  int             n_checked = 0;
  int             n_fail = 0;
  int             cycle_count = 0;

  pll_divider_search i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_crystal_hz   (in_crystal_hz),
    .in_target_hz    (in_target_hz),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_best_hz     (out_best_hz),
    .out_prediv_two  (out_prediv_two),
    .out_mult_two    (out_mult_two),
    .out_prediv_one  (out_prediv_one),
    .out_mult_one    (out_mult_one),
    .out_flash_ws    (out_flash_ws)
  );

  // Walk the whole setting space in search order; keep the first setting that reaches the best
  function automatic pll_setting_t search_best_setting(input logic [XTAL_W-1:0] crystal,
                                                       input logic [TARGET_W-1:0] target);
    pll_setting_t res;
    logic [63:0]  fa;
    logic [63:0]  fb;
    logic [63:0]  top;
    int unsigned  da;
    int unsigned  ma;
    int unsigned  db;
    int unsigned  mb;
    res = '0;
    top = '0;
    for (da = 1; da <= 16; da++) begin
      for (ma = 8; ma <= 20; ma++) begin
        if (ma > 14 && ma != 16 && ma != 20) continue;
        fa = (64'(crystal) / 64'(da)) * 64'(ma);
        if (fa < 64'(STAGE_MIN_HZ) || fa > 64'(STAGE_A_MAX_HZ)) continue;
        for (db = 1; db <= 16; db++) begin
          for (mb = MB_FIRST; mb <= MB_HALF_CODE; mb++) begin
            if (mb == MB_HALF_CODE) begin
              fb = (fa / 64'(db)) * 64'(MB_HALF_NUM) / 64'd2;
            end else begin
              fb = (fa / 64'(db)) * 64'(mb);
            end
            if (fb < 64'(STAGE_MIN_HZ) || fb > 64'(target)) continue;
            if (fb > top) begin
              top            = fb;
              res.prediv_two = SEL_W'(da);
              res.mult_two   = SEL_W'(ma);
              res.prediv_one = SEL_W'(db);
              res.mult_one   = MB_W'(mb);
            end
          end
        end
      end
    end
    res.found   = (top != 0);
    res.best_hz = HZ_W'(top);
    if (target < WS_ONE_HZ) begin
      res.flash_ws = WS_ZERO;
    end else if (target < WS_TWO_HZ) begin
      res.flash_ws = WS_ONE;
    end else begin
      res.flash_ws = WS_TWO;
    end
    return res;
  endfunction

  task automatic add_request(input logic [XTAL_W-1:0] crystal,
                             input logic [TARGET_W-1:0] target);
    clock_request_t req;
    req.crystal = crystal;
    req.target  = target;
    request_queue.push_back(req);
  endtask

  task automatic note_failure(input string msg);
    n_fail++;
    if (n_fail <= 10) begin
      $display("%s", msg);
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Sender: hold the request while stalled, advance once it is taken
  always @(posedge clk) begin
    clock_request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      sender_gap = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_settings.push_back(search_best_setting(in_crystal_hz, in_target_hz));
        if (!calm && $urandom_range(0, 2) == 0) begin
          sender_gap = $urandom_range(1, 5);
        end
      end
      if (sender_gap > 0 || request_queue.size() == 0) begin
        in_valid <= 1'b0;
        if (sender_gap > 0) begin
          sender_gap--;
        end
      end else begin
        req = request_queue.pop_front();
        in_valid      <= 1'b1;
        in_crystal_hz <= req.crystal;
        in_target_hz  <= req.target;
      end
      calm <= (request_queue.size() <= CALM_TAIL);
    end
  end

  // Receiver stall: random bursts, plus the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hold the result side long enough for a finished search to back up into the input
  initial begin
    wait (n_checked >= 6);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    pll_setting_t want;
    pll_setting_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_found, out_best_hz, out_prediv_two, out_mult_two, out_prediv_one,
             out_mult_one, out_flash_ws};
      if (expected_settings.size() == 0) begin
        note_failure($sformatf("unexpected result: found=%0d best=%0d", got.found, got.best_hz));
      end else begin
        want = expected_settings.pop_front();
        n_checked++;
        if (got.found !== want.found || got.best_hz !== want.best_hz ||
            got.prediv_two !== want.prediv_two || got.mult_two !== want.mult_two ||
            got.prediv_one !== want.prediv_one || got.mult_one !== want.mult_one ||
            got.flash_ws !== want.flash_ws) begin
          note_failure({
            $sformatf("mismatch: exp found=%0d best=%0d pd2=%0d m2=%0d pd1=%0d m1=%0d ws=%0d",
                      want.found, want.best_hz, want.prediv_two, want.mult_two,
                      want.prediv_one, want.mult_one, want.flash_ws),
            $sformatf(", got found=%0d best=%0d pd2=%0d m2=%0d pd1=%0d m1=%0d ws=%0d",
                      got.found, got.best_hz, got.prediv_two, got.mult_two,
                      got.prediv_one, got.mult_one, got.flash_ws)});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    logic [XTAL_W-1:0]   crystal;
    logic [TARGET_W-1:0] target;
    int                  pick;
    int                  k;

    // Directed: zeros, all-ones, wait-state edges, stage bounds, no-solution cases
    add_request('0, '0);
    add_request('0, TARGET_W'(72_000_000));
    add_request(XTAL_W'(50_000_000), '0);
    add_request({XTAL_W{1'b1}}, {TARGET_W{1'b1}});
    add_request({XTAL_W{1'b1}}, TARGET_W'(72_000_000));
    add_request(XTAL_W'(50_000_000), TARGET_W'(100_000_000));
    add_request(XTAL_W'(8_000_000), TARGET_W'(72_000_000));
    add_request(XTAL_W'(25_000_000), TARGET_W'(72_000_000));
    add_request(XTAL_W'(12_000_000), TARGET_W'(48_000_000));
    add_request(XTAL_W'(8_000_000), TARGET_W'(17_999_999));
    add_request(XTAL_W'(8_000_000), TARGET_W'(18_000_000));
    add_request(XTAL_W'(16_000_000), TARGET_W'(23_999_999));
    add_request(XTAL_W'(16_000_000), TARGET_W'(24_000_000));
    add_request(XTAL_W'(16_000_000), TARGET_W'(47_999_999));
    add_request(XTAL_W'(16_000_000), TARGET_W'(48_000_000));
    add_request(XTAL_W'(899_999), TARGET_W'(100_000_000));
    add_request(XTAL_W'(900_000), TARGET_W'(100_000_000));
    add_request(XTAL_W'(1), {TARGET_W{1'b1}});
    add_request(XTAL_W'(8_000_000), TARGET_W'(52_000_000));
    add_request(XTAL_W'(10_000_000), TARGET_W'(65_000_000));
    add_request(XTAL_W'(25_000_000), {TARGET_W{1'b1}});

    for (k = 0; k < N_RANDOM; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        crystal = XTAL_W'($urandom);
        target  = TARGET_W'($urandom);
      end else if (pick == 1) begin
        crystal = XTAL_W'($urandom_range(1_000_000, 50_000_000));
        target  = TARGET_W'($urandom_range(0, 30_000_000));
      end else if (pick == 2) begin
        case ($urandom_range(0, 6))
          0:       crystal = XTAL_W'(4_000_000);
          1:       crystal = XTAL_W'(8_000_000);
          2:       crystal = XTAL_W'(10_000_000);
          3:       crystal = XTAL_W'(12_000_000);
          4:       crystal = XTAL_W'(16_000_000);
          5:       crystal = XTAL_W'(20_000_000);
          default: crystal = XTAL_W'(25_000_000);
        endcase
        case ($urandom_range(0, 3))
          0:       target = TARGET_W'(24_000_000);
          1:       target = TARGET_W'(36_000_000);
          2:       target = TARGET_W'(48_000_000);
          default: target = TARGET_W'(72_000_000);
        endcase
      end else begin
        crystal = XTAL_W'($urandom_range(1_000_000, 50_000_000));
        target  = TARGET_W'($urandom_range(18_000_000, 100_000_000));
      end
      add_request(crystal, target);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Poll on the falling edge so the sender's updates have settled
    while (request_queue.size() != 0 || in_valid) @(negedge clk);
    while (expected_settings.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (n_fail == 0 && expected_settings.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
